FILE: sv/llws_pkg.sv
package llws_pkg;

  // Default sizing
  localparam int DEF_MAX_WORKERS = 64;
  localparam int DEF_TIME_BITS   = 48;

  // Fixed field widths
  localparam int CFG_W       = 7;
  localparam int DUR_W       = 30;
  localparam int IDX_OUT_W   = 6;
  localparam int START_W     = 48;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int RST_WORKERS = 64;

  // Register map: word index taken from paddr[2]
  localparam logic REG_WORKER_COUNT = 1'b0;

  // Control from the top level to the cell row
  typedef struct packed {
    logic clear;   // reload every cell with time zero and its own index
    logic update;  // re-insert the broadcast key this cycle
  } llws_ctrl_t;

endpackage

FILE: sv/llws_cell.sv
module llws_cell #(
  parameter int TIME_BITS = llws_pkg::DEF_TIME_BITS,
  parameter int IDX_W     = 6,
  parameter int CELL_ID   = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  llws_pkg::llws_ctrl_t ctrl_i,
  input  logic [TIME_BITS-1:0] key_time_i,
  input  logic [IDX_W-1:0]     key_idx_i,
  input  logic                 active_i,
  input  logic                 right_active_i,
  input  logic [TIME_BITS-1:0] right_time_i,
  input  logic [IDX_W-1:0]     right_idx_i,
  input  logic                 right_lt_i,
  output logic [TIME_BITS-1:0] time_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic                 lt_o
);

  localparam logic [IDX_W-1:0] OWN_IDX = IDX_W'(CELL_ID);
  localparam bit               IS_HEAD = (CELL_ID == 0);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [IDX_W-1:0]     idx_q, idx_d;

  // Own key sorts before the key being re-inserted
  assign lt_o = (time_q < key_time_i) || ((time_q == key_time_i) && (idx_q < key_idx_i));

  // Shift from right if it sorts first, else take key if head or own sorts first
  always_comb begin
    time_d = time_q;
    idx_d  = idx_q;
    if (ctrl_i.clear) begin
      time_d = '0;
      idx_d  = OWN_IDX;
    end else if (ctrl_i.update && active_i) begin
      if (right_active_i && right_lt_i) begin
        time_d = right_time_i;
        idx_d  = right_idx_i;
      end else if (IS_HEAD || lt_o) begin
        time_d = key_time_i;
        idx_d  = key_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      idx_q  <= OWN_IDX;
    end else begin
      time_q <= time_d;
      idx_q  <= idx_d;
    end
  end

  assign time_o = time_q;
  assign idx_o  = idx_q;

endmodule

FILE: sv/llws_chain.sv
module llws_chain #(
  parameter int MAX_WORKERS = llws_pkg::DEF_MAX_WORKERS,
  parameter int TIME_BITS   = llws_pkg::DEF_TIME_BITS,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  llws_pkg::llws_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [TIME_BITS-1:0] key_time_i,
  input  logic [IDX_W-1:0]     key_idx_i,
  output logic [TIME_BITS-1:0] head_time_o,
  output logic [IDX_W-1:0]     head_idx_o
);

  logic [TIME_BITS-1:0] time_w [MAX_WORKERS];
  logic [IDX_W-1:0]     idx_w  [MAX_WORKERS];
  logic                 lt_w   [MAX_WORKERS];
  logic                 act_w  [MAX_WORKERS];

  // Row of sorted cells, slot 0 on the left
  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    logic [TIME_BITS-1:0] r_time;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_lt;
    logic                 r_act;

    assign act_w[i] = (count_i > CNT_W'(i));

    if (i + 1 < MAX_WORKERS) begin : g_mid
      assign r_time = time_w[i+1];
      assign r_idx  = idx_w[i+1];
      assign r_lt   = lt_w[i+1];
      assign r_act  = act_w[i+1];
    end else begin : g_last
      assign r_time = '0;
      assign r_idx  = '0;
      assign r_lt   = 1'b0;
      assign r_act  = 1'b0;
    end

    llws_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .CELL_ID   (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl_i),
      .key_time_i     (key_time_i),
      .key_idx_i      (key_idx_i),
      .active_i       (act_w[i]),
      .right_active_i (r_act),
      .right_time_i   (r_time),
      .right_idx_i    (r_idx),
      .right_lt_i     (r_lt),
      .time_o         (time_w[i]),
      .idx_o          (idx_w[i]),
      .lt_o           (lt_w[i])
    );
  end

  assign head_time_o = time_w[0];
  assign head_idx_o  = idx_w[0];

endmodule

FILE: sv/least_loaded_worker_scheduler_unit.sv
// A request's answer is captured in the output register when it is accepted.
// After each accepted request the cell row re-inserts the updated key, and the
// next request waits for it; a stalled output also holds new requests off.
// Reset: all workers free at time zero, slot i holds worker i, worker count 64
// (clamped to MAX_WORKERS). Writing worker_count restores the same slot contents.
module least_loaded_worker_scheduler_unit #(
  parameter int MAX_WORKERS = llws_pkg::DEF_MAX_WORKERS,
  parameter int TIME_BITS   = llws_pkg::DEF_TIME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [llws_pkg::ADDR_W-1:0]    paddr,
  input  logic [llws_pkg::DATA_W-1:0]    pwdata,
  output logic [llws_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // job requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [llws_pkg::DUR_W-1:0]     job_duration_i,
  // assignments
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [llws_pkg::IDX_OUT_W-1:0] worker_index_o,
  output logic [llws_pkg::START_W-1:0]   start_time_o
);

  localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
  localparam int CMP_W   = (CNT_W > llws_pkg::CFG_W) ? CNT_W : llws_pkg::CFG_W;
  localparam int RST_CNT = (llws_pkg::RST_WORKERS < MAX_WORKERS) ?
                           llws_pkg::RST_WORKERS : MAX_WORKERS;

  llws_pkg::llws_ctrl_t ctrl;

  logic                 cfg_wr;
  logic [CMP_W-1:0]     wr_val;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 busy_q;
  logic                 out_valid_q;
  logic                 in_acc;
  logic [TIME_BITS-1:0] head_time;
  logic [IDX_W-1:0]     head_idx;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] new_time_q;
  logic [IDX_W-1:0]     new_idx_q;
  logic [IDX_W+llws_pkg::IDX_OUT_W-1:0]     idx_ext;
  logic [TIME_BITS+llws_pkg::START_W-1:0]   time_ext;
  logic [llws_pkg::IDX_OUT_W-1:0] out_idx_q;
  logic [llws_pkg::START_W-1:0]   out_time_q;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == llws_pkg::REG_WORKER_COUNT);
  assign wr_val = CMP_W'(pwdata[llws_pkg::CFG_W-1:0]);
  assign prdata = (paddr[2] == llws_pkg::REG_WORKER_COUNT) ?
                  llws_pkg::DATA_W'(count_q) : '0;

  // Clamp the written count to 1..MAX_WORKERS
  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      if (wr_val == '0) begin
        count_d = CNT_W'(1);
      end else if (wr_val > CMP_W'(MAX_WORKERS)) begin
        count_d = CNT_W'(MAX_WORKERS);
      end else begin
        count_d = CNT_W'(wr_val);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(RST_CNT);
    end else begin
      count_q <= count_d;
    end
  end

  // Request handshake: one job in flight, output register must be free or draining
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // Saturating free-time update
  assign sum = {1'b0, head_time} + (TIME_BITS + 1)'(job_duration_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= in_acc;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_ext  = {{llws_pkg::IDX_OUT_W{1'b0}}, head_idx};
  assign time_ext = {{llws_pkg::START_W{1'b0}}, head_time};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_time_q <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
      new_idx_q  <= head_idx;
      out_idx_q  <= idx_ext[llws_pkg::IDX_OUT_W-1:0];
      out_time_q <= time_ext[llws_pkg::START_W-1:0];
    end
  end

  // Cell row
  assign ctrl.clear  = cfg_wr;
  assign ctrl.update = busy_q;

  llws_chain #(
    .MAX_WORKERS (MAX_WORKERS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .count_i     (count_q),
    .key_time_i  (new_time_q),
    .key_idx_i   (new_idx_q),
    .head_time_o (head_time),
    .head_idx_o  (head_idx)
  );

  assign out_valid_o    = out_valid_q;
  assign worker_index_o = out_idx_q;
  assign start_time_o   = out_time_q;

  // Checks
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && out_valid_q))
    else $error("accepted request did not start update and result");

  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o)
    else $error("request accepted during re-insertion");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(MAX_WORKERS)))
    else $error("worker count out of range");

  a_clear_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> ((head_time == '0) && (head_idx == '0)))
    else $error("slot 0 not reset by count write");

endmodule
